// ===== src/arbc_pkg.sv =====
// ----------------------------------------------------------------------------
// arbc_pkg
// Types and codes shared by the allocated-region bounds checker and its testbench.
// ----------------------------------------------------------------------------
package arbc_pkg;

  localparam int unsigned FIELD_BITS = 48;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_OUTSIDE      = 3'd1,
    STATUS_EXCEEDS      = 3'd2,
    STATUS_UNKNOWN_FREE = 3'd3,
    STATUS_FULL         = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    STATE_CLEAR,
    STATE_IDLE,
    STATE_SCAN,
    STATE_DRAIN,
    STATE_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [FIELD_BITS-1:0] address;
    logic [FIELD_BITS-1:0] length;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [FIELD_BITS-1:0] region_length;
  } rsp_t;

endpackage

// ===== src/arbc_ram.sv =====
// ----------------------------------------------------------------------------
// arbc_ram
// Generic RAM: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module arbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/allocated_region_bounds_checker.sv =====
// ----------------------------------------------------------------------------
// allocated_region_bounds_checker
// Table of allocated regions (base, length) kept in one RAM. Each item
// allocates, frees, checks an access or does nothing (FUNC_NONE) by a full sweep over the table.
// ----------------------------------------------------------------------------
//
//  channel   ports                  handshake
//  --------  ---------------------  ---------------------------------------
//  request   req_i (func/addr/len)  taken when start_i && !busy_o
//  result    rsp_o (status/len)     shown one cycle with done_o, no stall
//
//  An item runs from acceptance to done_o through STATE_SCAN, one RAM
//  read per table entry; STATE_DRAIN, which folds in the last read data;
//  STATE_DONE, which decides and writes back; and the result register.
//  After reset the RAM is cleared one entry a cycle with busy_o high.
//  The receiver cannot stall; busy_o is low again while the result shows.
// ----------------------------------------------------------------------------
module allocated_region_bounds_checker #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned ADDR_BITS     = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  arbc_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            done_o,
  output arbc_pkg::rsp_t  rsp_o
);

  localparam int unsigned StoreBits =
    (ADDR_BITS < arbc_pkg::FIELD_BITS) ? ADDR_BITS : arbc_pkg::FIELD_BITS;
  localparam int unsigned SumBits  = StoreBits + 1;
  localparam int unsigned IdxBits  = $clog2(TABLE_ENTRIES);
  localparam int unsigned WordBits = 1 + 2 * StoreBits;
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(TABLE_ENTRIES - 1);

  arbc_pkg::state_e state_q, state_d;
  logic [IdxBits-1:0] cnt_q, cnt_d;

  // Current item
  arbc_pkg::func_e        op_q;
  logic [StoreBits-1:0]   addr_q;
  logic [StoreBits-1:0]   len_q;
  logic [SumBits-1:0]     acc_end_q;

  // RAM ports
  logic                 ram_we;
  logic [IdxBits-1:0]   ram_waddr;
  logic [WordBits-1:0]  ram_wdata;
  logic                 ram_re;
  logic [WordBits-1:0]  ram_rdata;

  logic                 rd_vld_q;
  logic [IdxBits-1:0]   rd_idx_q;

  // Sweep results
  logic                 hit_q;
  logic [IdxBits-1:0]   hit_idx_q;
  logic                 slot_q;
  logic [IdxBits-1:0]   slot_idx_q;
  logic                 contain_q;
  logic                 ovl_q;
  logic [StoreBits-1:0] best_base_q;
  logic [StoreBits-1:0] best_len_q;

  logic                 done_q, done_d;
  arbc_pkg::rsp_t       rsp_q, rsp_d;

  logic                 accept;
  logic                 e_used;
  logic [StoreBits-1:0] e_base;
  logic [StoreBits-1:0] e_len;
  logic [SumBits-1:0]   e_end;
  logic                 e_match;
  logic                 e_contain;
  logic                 e_overlap;

  assign busy_o = (state_q != arbc_pkg::STATE_IDLE);
  assign accept = start_i && !busy_o;

  arbc_ram #(
    .WIDTH (WordBits),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // Per-entry tests on the registered read data
  assign e_used    = ram_rdata[WordBits-1];
  assign e_base    = ram_rdata[2*StoreBits-1:StoreBits];
  assign e_len     = ram_rdata[StoreBits-1:0];
  assign e_end     = {1'b0, e_base} + {1'b0, e_len};
  assign e_match   = (e_base == addr_q);
  assign e_contain = (e_base <= addr_q) && (e_end >= acc_end_q);
  assign e_overlap = (e_end >= {1'b0, addr_q}) && ({1'b0, e_base} <= acc_end_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= arbc_pkg::func_e'(req_i.func);
      addr_q    <= req_i.address[StoreBits-1:0];
      len_q     <= req_i.length[StoreBits-1:0];
      acc_end_q <= {1'b0, req_i.address[StoreBits-1:0]}
                 + {1'b0, req_i.length[StoreBits-1:0]};
    end
    rd_idx_q <= cnt_q;
    rsp_q    <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arbc_pkg::STATE_CLEAR;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      done_q      <= 1'b0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      slot_q      <= 1'b0;
      slot_idx_q  <= '0;
      contain_q   <= 1'b0;
      ovl_q       <= 1'b0;
      best_base_q <= '0;
      best_len_q  <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= ram_re;
      done_q   <= done_d;
      if (accept) begin
        hit_q     <= 1'b0;
        slot_q    <= 1'b0;
        contain_q <= 1'b0;
        ovl_q     <= 1'b0;
      end else if (rd_vld_q) begin
        if (e_used) begin
          if (e_match && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= rd_idx_q;
          end
          if (e_contain) begin
            contain_q <= 1'b1;
          end
          // keep the overlapping region with the lowest base
          if (e_overlap && (!ovl_q || (e_base < best_base_q))) begin
            ovl_q       <= 1'b1;
            best_base_q <= e_base;
            best_len_q  <= e_len;
          end
        end else if (!slot_q) begin
          slot_q     <= 1'b1;
          slot_idx_q <= rd_idx_q;
        end
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    done_d    = 1'b0;
    rsp_d     = rsp_q;

    unique case (state_q)
      arbc_pkg::STATE_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + IdxBits'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = arbc_pkg::STATE_IDLE;
        end
      end
      arbc_pkg::STATE_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = arbc_pkg::STATE_SCAN;
        end
      end
      arbc_pkg::STATE_SCAN: begin
        ram_re = 1'b1;
        cnt_d  = cnt_q + IdxBits'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = arbc_pkg::STATE_DRAIN;
        end
      end
      arbc_pkg::STATE_DRAIN: begin
        // last read data is folded in this cycle
        state_d = arbc_pkg::STATE_DONE;
      end
      arbc_pkg::STATE_DONE: begin
        state_d                = arbc_pkg::STATE_IDLE;
        done_d                 = 1'b1;
        rsp_d.status           = arbc_pkg::STATUS_OK;
        rsp_d.region_length    = '0;
        unique case (op_q)
          arbc_pkg::FUNC_ALLOC: begin
            if (!hit_q) begin
              if (slot_q) begin
                ram_we    = 1'b1;
                ram_waddr = slot_idx_q;
                ram_wdata = {1'b1, addr_q, len_q};
              end else begin
                rsp_d.status = arbc_pkg::STATUS_FULL;
              end
            end
          end
          arbc_pkg::FUNC_FREE: begin
            if (hit_q) begin
              ram_we    = 1'b1;
              ram_waddr = hit_idx_q;
            end else begin
              rsp_d.status = arbc_pkg::STATUS_UNKNOWN_FREE;
            end
          end
          arbc_pkg::FUNC_CHECK: begin
            if (!contain_q) begin
              if (ovl_q) begin
                rsp_d.status        = arbc_pkg::STATUS_EXCEEDS;
                rsp_d.region_length = arbc_pkg::FIELD_BITS'(best_len_q);
              end else begin
                rsp_d.status = arbc_pkg::STATUS_OUTSIDE;
              end
            end
          end
          arbc_pkg::FUNC_NONE: begin
            rsp_d.status = arbc_pkg::STATUS_OK;
          end
          default: begin
            rsp_d.status = arbc_pkg::STATUS_OK;
          end
        endcase
      end
      default: begin
        state_d = arbc_pkg::STATE_IDLE;
      end
    endcase
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== bench/allocated_region_bounds_checker_tb.sv =====
// ----------------------------------------------------------------------------
// allocated_region_bounds_checker_tb
// Drives allocate, free and check items into the region table and compares
// every result with its pinned answer or with a predictor that keeps its own
// copy of the table. A short table of directed items comes first. Random
// segments follow: mixed traffic around a moving address window, runs that
// fill the table to overflow, and runs that free every region.
// ----------------------------------------------------------------------------
module allocated_region_bounds_checker_tb;

  localparam int TABLE_ENTRIES = 64;
  localparam int RANDOM_ITEMS  = 950;
  localparam int MAX_GAP       = 18;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  arbc_pkg::req_t req = '0;
  logic busy;
  logic done;
  arbc_pkg::rsp_t rsp;

  allocated_region_bounds_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ADDR_BITS    (arbc_pkg::FIELD_BITS)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start_i(start),
    .req_i  (req),
    .busy_o (busy),
    .done_o (done),
    .rsp_o  (rsp)
  );

  always #6 clk = ~clk;

  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Predicted table contents, updated when an item is accepted.
  logic        region_used [TABLE_ENTRIES] = '{default: 1'b0};
  logic [47:0] region_base [TABLE_ENTRIES] = '{default: '0};
  logic [47:0] region_len  [TABLE_ENTRIES] = '{default: '0};

  arbc_pkg::rsp_t verdict_q [$];
  int   mismatch_count = 0;
  int   items_sent     = 0;

  // Random traffic centers on a window that moves once per segment.
  logic [47:0] win_base   = '0;
  logic [63:0] span_mask  = 64'hff;
  logic        burst_mode = 1'b0;

  function automatic arbc_pkg::rsp_t apply_region_op(input arbc_pkg::req_t r);
    arbc_pkg::rsp_t res;
    int          slot;
    logic        hit;
    logic [47:0] low_base;
    logic [47:0] low_len;
    logic [48:0] acc_end;
    logic [48:0] reg_end;
    res      = '0;
    slot     = -1;
    hit      = 1'b0;
    low_base = '0;
    low_len  = '0;
    res.status = arbc_pkg::STATUS_OK;
    case (arbc_pkg::func_e'(r.func))
      arbc_pkg::FUNC_ALLOC: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (region_used[i]) begin
            if (region_base[i] == r.address) return res;
          end else if (slot < 0) begin
            slot = i;
          end
        end
        if (slot < 0) begin
          res.status = arbc_pkg::STATUS_FULL;
        end else begin
          region_used[slot] = 1'b1;
          region_base[slot] = r.address;
          region_len[slot]  = r.length;
        end
      end
      arbc_pkg::FUNC_FREE: begin
        res.status = arbc_pkg::STATUS_UNKNOWN_FREE;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (region_used[i] && region_base[i] == r.address) begin
            region_used[i] = 1'b0;
            res.status = arbc_pkg::STATUS_OK;
            break;
          end
        end
      end
      arbc_pkg::FUNC_CHECK: begin
        acc_end = {1'b0, r.address} + {1'b0, r.length};
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (region_used[i]) begin
            reg_end = {1'b0, region_base[i]} + {1'b0, region_len[i]};
            if (region_base[i] <= r.address && reg_end >= acc_end) return res;
            // touching ends count as overlap
            if (reg_end >= {1'b0, r.address} && {1'b0, region_base[i]} <= acc_end &&
                (!hit || region_base[i] < low_base)) begin
              hit      = 1'b1;
              low_base = region_base[i];
              low_len  = region_len[i];
            end
          end
        end
        if (hit) begin
          res.status        = arbc_pkg::STATUS_EXCEEDS;
          res.region_length = low_len;
        end else begin
          res.status = arbc_pkg::STATUS_OUTSIDE;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int regions_in_use();
    int cnt;
    cnt = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) if (region_used[i]) cnt++;
    return cnt;
  endfunction

  function automatic void pick_region(output logic [63:0] b, output logic [63:0] n);
    int k;
    k = $urandom_range(0, regions_in_use() - 1);
    b = '0;
    n = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (region_used[i]) begin
        if (k == 0) begin
          b = {16'h0, region_base[i]};
          n = {16'h0, region_len[i]};
          return;
        end
        k--;
      end
    end
  endfunction

  function automatic logic [47:0] window_addr();
    logic [63:0] off;
    off = rand64() & span_mask;
    return win_base + off[47:0];
  endfunction

  function automatic arbc_pkg::req_t make_alloc(input logic allow_dup);
    arbc_pkg::req_t r;
    logic [63:0] b;
    logic [63:0] n;
    r.func    = arbc_pkg::FUNC_ALLOC;
    r.address = window_addr();
    n = rand64();
    case ($urandom_range(0, 15))
      0:       r.length = n[47:0];
      1:       r.length = '0;
      default: begin
        n = n & span_mask;
        r.length = n[47:0];
      end
    endcase
    if (allow_dup && regions_in_use() != 0 && $urandom_range(0, 7) == 0) begin
      pick_region(b, n);
      r.address = b[47:0];
    end
    return r;
  endfunction

  function automatic arbc_pkg::req_t make_free();
    arbc_pkg::req_t r;
    logic [63:0] b;
    logic [63:0] n;
    r.func    = arbc_pkg::FUNC_FREE;
    r.address = window_addr();
    n = rand64();
    r.length = n[47:0];
    if (regions_in_use() != 0 && $urandom_range(0, 3) != 0) begin
      pick_region(b, n);
      r.address = b[47:0];
    end
    return r;
  endfunction

  function automatic arbc_pkg::req_t make_check();
    arbc_pkg::req_t r;
    logic [63:0] b;
    logic [63:0] n;
    logic [63:0] off;
    logic [63:0] tmp;
    r.func    = arbc_pkg::FUNC_CHECK;
    r.address = window_addr();
    tmp = rand64() & span_mask;
    r.length = tmp[47:0];
    if (regions_in_use() == 0 || $urandom_range(0, 3) == 0) return r;
    pick_region(b, n);
    case ($urandom_range(0, 2))
      0: begin
        // somewhere inside the region
        off = rand64() % (n + 64'd1);
        tmp = b + off;
        r.address = tmp[47:0];
        tmp = rand64() % (n - off + 64'd1);
        r.length = tmp[47:0];
      end
      1: begin
        // straddle the upper end
        off = rand64() & 64'hff;
        tmp = b + n - off;
        r.address = tmp[47:0];
        tmp = off + (rand64() & 64'hff);
        r.length = tmp[47:0];
      end
      default: begin
        // start just below the base
        tmp = b - (rand64() & 64'hff);
        r.address = tmp[47:0];
        tmp = rand64() & (span_mask | 64'h1ff);
        r.length = tmp[47:0];
      end
    endcase
    return r;
  endfunction

  function automatic arbc_pkg::req_t make_noop();
    arbc_pkg::req_t r;
    logic [63:0] v;
    r.func = arbc_pkg::FUNC_NONE;
    v = rand64();
    r.address = v[47:0];
    v = rand64();
    r.length = v[47:0];
    return r;
  endfunction

  task automatic issue_item(input arbc_pkg::req_t r, input logic pinned = 1'b0,
                            input arbc_pkg::rsp_t answer = '0);
    int   gap;
    arbc_pkg::rsp_t want;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    want = apply_region_op(r);
    if (pinned) want = answer;
    verdict_q.push_back(want);
    items_sent++;
  endtask

  always @(posedge clk) begin
    arbc_pkg::rsp_t want;
    if (rst_n && done) begin
      if (verdict_q.size() == 0) begin
        $error("status: expected none pending, got %0d", rsp.status);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.region_length !== want.region_length) begin
          $error("region_length: expected 0x%0h, got 0x%0h",
                 want.region_length, rsp.region_length);
          mismatch_count++;
        end
      end
    end
  end

  typedef struct packed {
    arbc_pkg::req_t op;
    logic           pinned;
    arbc_pkg::rsp_t answer;
  } directed_step_t;

  localparam int DIRECTED_ROWS = 22;
  localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

  // Rows with pinned = 0 take their answer from the predictor.
  directed_step_t directed_steps [DIRECTED_ROWS] = '{
    '{'{arbc_pkg::FUNC_CHECK, 48'h0,    48'h0},    1'b1, '{arbc_pkg::STATUS_OUTSIDE, 48'h0}},
    '{'{arbc_pkg::FUNC_FREE,  48'h0,    ALL_ONES}, 1'b1,
      '{arbc_pkg::STATUS_UNKNOWN_FREE, 48'h0}},
    '{'{arbc_pkg::FUNC_NONE,  ALL_ONES, ALL_ONES}, 1'b1, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_ALLOC, 48'h1000, 48'h100},  1'b1, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_ALLOC, 48'h1000, 48'h5},    1'b1, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_CHECK, 48'h1000, 48'h100},  1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_CHECK, 48'h1000, 48'h101},  1'b1,
      '{arbc_pkg::STATUS_EXCEEDS, 48'h100}},
    '{'{arbc_pkg::FUNC_CHECK, 48'h1100, 48'h0},    1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_CHECK, 48'h1101, 48'h0},    1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_CHECK, 48'h0f00, 48'h100},  1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_ALLOC, 48'h1080, 48'h200},  1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_CHECK, 48'h1050, 48'h100},  1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_ALLOC, 48'h2000, 48'h0},    1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_CHECK, 48'h2000, 48'h0},    1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_ALLOC, ALL_ONES, ALL_ONES}, 1'b1, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_CHECK, ALL_ONES, ALL_ONES}, 1'b1, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_CHECK, 48'h0,    ALL_ONES}, 1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_FREE,  48'h1000, 48'h0},    1'b1, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_FREE,  48'h1000, 48'h0},    1'b1,
      '{arbc_pkg::STATUS_UNKNOWN_FREE, 48'h0}},
    '{'{arbc_pkg::FUNC_CHECK, 48'h1050, 48'h100},  1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_FREE,  ALL_ONES, 48'h0},    1'b0, '{arbc_pkg::STATUS_OK, 48'h0}},
    '{'{arbc_pkg::FUNC_NONE,  48'h0,    48'h0},    1'b1, '{arbc_pkg::STATUS_OK, 48'h0}}
  };

  initial begin
    logic [63:0] v;
    logic [47:0] bases [$];
    int          pick;
    int          seg_len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      issue_item(directed_steps[i].op, directed_steps[i].pinned, directed_steps[i].answer);
    end

    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      v = rand64();
      case ($urandom_range(0, 3))
        0:       win_base = '0;
        1:       win_base = ALL_ONES - (v[47:0] & 48'hf_ffff);
        default: win_base = v[47:0];
      endcase
      case ($urandom_range(0, 3))
        0:       span_mask = 64'hff;
        1:       span_mask = 64'hfff;
        2:       span_mask = 64'hf_ffff;
        default: span_mask = 64'hffff_ffff_ffff;
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);

      case ($urandom_range(0, 9))
        0: begin
          // fill the table, then overflow it
          while (regions_in_use() < TABLE_ENTRIES) issue_item(make_alloc(1'b0));
          repeat ($urandom_range(1, 3)) issue_item(make_alloc(1'b0));
          repeat ($urandom_range(2, 6)) issue_item(make_check());
        end
        1: begin
          // release every region
          bases.delete();
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (region_used[i]) bases.push_back(region_base[i]);
          end
          bases.shuffle();
          foreach (bases[i]) issue_item('{arbc_pkg::FUNC_FREE, bases[i], 48'h0});
        end
        default: begin
          seg_len = $urandom_range(20, 40);
          repeat (seg_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      issue_item(make_alloc(1'b1));
            else if (pick < 60) issue_item(make_free());
            else if (pick < 95) issue_item(make_check());
            else                issue_item(make_noop());
          end
        end
      endcase
    end

    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
